[rtl/core/pme_pkg.sv]
package pme_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LIMIT_W   = 31;
  localparam int unsigned DT_W      = 24;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned MASK_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned AXES      = 3;
  localparam int unsigned AXIS_W    = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FORCE   = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASS        = 3'd0,
    CFG_LIMIT       = 3'd1,
    CFG_START_POS_X = 3'd2,
    CFG_START_POS_Y = 3'd3,
    CFG_START_POS_Z = 3'd4,
    CFG_START_VEL_X = 3'd5,
    CFG_START_VEL_Y = 3'd6,
    CFG_START_VEL_Z = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_V,
    ST_ADD_V,
    ST_MUL_P,
    ST_ADD_P,
    ST_CHECK,
    ST_MUL_B,
    ST_BOUNCE,
    ST_NEXT,
    ST_OUT
  } state_e;

endpackage

[rtl/core/pme_if.sv]
interface pme_in_if;
  logic                                valid;
  logic                                ready;
  logic        [pme_pkg::FUNC_W-1:0]   func;
  logic signed [pme_pkg::DATA_W-1:0]   force_x;
  logic signed [pme_pkg::DATA_W-1:0]   force_y;
  logic signed [pme_pkg::DATA_W-1:0]   force_z;
  logic        [pme_pkg::DT_W-1:0]     time_step;

  modport source (output valid, func, force_x, force_y, force_z, time_step, input ready);
  modport sink   (input valid, func, force_x, force_y, force_z, time_step, output ready);
endinterface

interface pme_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pme_pkg::DATA_W-1:0]   pos_x;
  logic signed [pme_pkg::DATA_W-1:0]   pos_y;
  logic signed [pme_pkg::DATA_W-1:0]   pos_z;
  logic signed [pme_pkg::DATA_W-1:0]   vel_x;
  logic signed [pme_pkg::DATA_W-1:0]   vel_y;
  logic signed [pme_pkg::DATA_W-1:0]   vel_z;
  logic        [pme_pkg::MASK_W-1:0]   bounce_mask;
  logic                                saturated;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, bounce_mask,
                  saturated, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, bounce_mask,
                  saturated, output ready);
endinterface

[rtl/core/pme_div.sv]
module pme_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [pme_pkg::DATA_W+FRAC_BITS-1:0]   dividend_i,
  input  logic [pme_pkg::DATA_W-1:0]             divisor_i,
  output logic                                   done_o,
  output logic [pme_pkg::DATA_W+FRAC_BITS-1:0]   quotient_o
);

  localparam int unsigned NUM_W = pme_pkg::DATA_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  localparam int unsigned DW    = pme_pkg::DATA_W;

  logic [DW-1:0]    rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DW:0]      trial;
  logic [DW+1:0]    diff;

  // One restoring step per cycle: the dividend shifts out of quo_q as quotient bits shift in.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DW+1]) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/core/point_mass_euler_integrator.sv]
// Channel   Dir  Beat contents
// in_ch     in   func, force_x/y/z, time_step
// out_ch    out  pos_x/y/z, vel_x/y/z, bounce_mask, saturated
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// Force, restart and unused func beats are taken in idle; in_ch.ready stays high.
// A tick works through the axes in turn: per axis the shared divider runs
// DATA_W + FRAC_BITS steps (skipped when mass is zero), then the shared 32x24 multiplier
// is used two or three times, each followed by a saturating add or (bounce) a reversal.
// in_ch.ready is low for the whole tick; a finished result waits in the output register.
// Reset clears body, start and sequencer state and loads mass 1.0 and limit 100.0.
module point_mass_euler_integrator #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pme_in_if.sink                            in_ch,
  pme_out_if.source                         out_ch,
  input  logic                              cfg_we_i,
  input  logic [pme_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pme_pkg::DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned DW     = pme_pkg::DATA_W;
  localparam int unsigned DTW    = pme_pkg::DT_W;
  localparam int unsigned NUM_W  = DW + FRAC_BITS;
  localparam int unsigned PROD_W = DW + DTW;
  localparam int unsigned TERM_W = PROD_W - FRAC_BITS;
  localparam int unsigned SUM_W  = TERM_W + 2;
  localparam int unsigned AW     = pme_pkg::AXIS_W;

  localparam logic [DTW-1:0] NINE_TENTHS =
      DTW'(((64'd9 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [DW-1:0] MASS_RST = DW'(64'd1 << FRAC_BITS);
  localparam logic [pme_pkg::LIMIT_W-1:0] LIMIT_RST =
      pme_pkg::LIMIT_W'(64'd100 << FRAC_BITS);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32'sh7fff_ffff);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(32'sh8000_0000);
  localparam logic [NUM_W-1:0] Q_POS_MAX = NUM_W'(32'h7fff_ffff);
  localparam logic [NUM_W-1:0] Q_NEG_MAX = NUM_W'(32'h8000_0000);
  localparam logic [AW-1:0] LAST_AXIS = AW'(pme_pkg::AXES - 1);

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
    mag = a[DW-1] ? DW'(-a) : DW'(a);
  endfunction

  function automatic logic [DW:0] sat_add(input logic signed [DW-1:0] a,
                                          input logic signed [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      sat_add = {1'b1, s[DW] ? 32'h8000_0000 : 32'h7fff_ffff};
    end else begin
      sat_add = {1'b0, s[DW-1:0]};
    end
  endfunction

  // configuration
  logic        [DW-1:0]                mass_q;
  logic        [pme_pkg::LIMIT_W-1:0]  limit_q;
  logic signed [DW-1:0]                start_pos_q [pme_pkg::AXES];
  logic signed [DW-1:0]                start_vel_q [pme_pkg::AXES];

  // body state
  logic signed [DW-1:0] force_q [pme_pkg::AXES], force_d [pme_pkg::AXES];
  logic signed [DW-1:0] accel_q [pme_pkg::AXES], accel_d [pme_pkg::AXES];
  logic signed [DW-1:0] vel_q   [pme_pkg::AXES], vel_d   [pme_pkg::AXES];
  logic signed [DW-1:0] pos_q   [pme_pkg::AXES], pos_d   [pme_pkg::AXES];

  // sequencer
  pme_pkg::state_e               state_q, state_d;
  logic [AW-1:0]                 axis_q, axis_d;
  logic [DTW-1:0]                dt_q, dt_d;
  logic                          neg_q, neg_d;
  logic                          clip_q, clip_d;
  logic [pme_pkg::MASK_W-1:0]    bounce_q, bounce_d;

  // shared multiplier
  logic [DW-1:0]     mul_a;
  logic [DTW-1:0]    mul_b;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [TERM_W-1:0] term;
  logic signed [SUM_W-1:0] term_s, add_base, sum_v;
  logic [DW:0]       sum_sat;

  // divider
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [NUM_W-1:0]  div_num;

  // bounds test
  logic signed [DW:0] pos_ext, lim_ext;
  logic               outside;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic signed [DW-1:0]       out_pos_q [pme_pkg::AXES], out_pos_d [pme_pkg::AXES];
  logic signed [DW-1:0]       out_vel_q [pme_pkg::AXES], out_vel_d [pme_pkg::AXES];
  logic [pme_pkg::MASK_W-1:0] out_mask_q, out_mask_d;
  logic                       out_sat_q, out_sat_d;

  logic signed [DW-1:0] in_force [pme_pkg::AXES];
  logic [DW:0]          force_add [pme_pkg::AXES];

  assign in_force[0] = in_ch.force_x;
  assign in_force[1] = in_ch.force_y;
  assign in_force[2] = in_ch.force_z;

  always_comb begin
    for (int i = 0; i < pme_pkg::AXES; i++) begin
      force_add[i] = sat_add(force_q[i], in_force[i]);
    end
  end

  assign div_num = {mag(force_q[axis_q]), FRAC_BITS'(0)};

  pme_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (mass_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign prod_d   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign term     = prod_q[PROD_W-1:FRAC_BITS];
  assign term_s   = neg_q ? -$signed({2'b00, term}) : $signed({2'b00, term});
  assign add_base = (state_q == pme_pkg::ST_ADD_P) ? SUM_W'(pos_q[axis_q])
                                                   : SUM_W'(vel_q[axis_q]);
  assign sum_v    = add_base + term_s;

  always_comb begin
    if (sum_v > SUM_MAX) begin
      sum_sat = {1'b1, 32'h7fff_ffff};
    end else if (sum_v < SUM_MIN) begin
      sum_sat = {1'b1, 32'h8000_0000};
    end else begin
      sum_sat = {1'b0, sum_v[DW-1:0]};
    end
  end

  assign pos_ext = (DW+1)'(pos_q[axis_q]);
  assign lim_ext = $signed({2'b00, limit_q});
  assign outside = (pos_ext > lim_ext) || (pos_ext < -lim_ext);

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    dt_d        = dt_q;
    neg_d       = neg_q;
    clip_d      = clip_q;
    bounce_d    = bounce_q;
    force_d     = force_q;
    accel_d     = accel_q;
    vel_d       = vel_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_pos_d   = out_pos_q;
    out_vel_d   = out_vel_q;
    out_mask_d  = out_mask_q;
    out_sat_d   = out_sat_q;
    div_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;

    case (state_q)
      pme_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.func)
            pme_pkg::FUNC_FORCE: begin
              for (int i = 0; i < pme_pkg::AXES; i++) begin
                force_d[i] = force_add[i][DW-1:0];
              end
            end
            pme_pkg::FUNC_RESTART: begin
              for (int i = 0; i < pme_pkg::AXES; i++) begin
                pos_d[i]   = start_pos_q[i];
                vel_d[i]   = start_vel_q[i];
                force_d[i] = '0;
                accel_d[i] = '0;
              end
            end
            pme_pkg::FUNC_TICK: begin
              dt_d     = in_ch.time_step;
              axis_d   = '0;
              clip_d   = 1'b0;
              bounce_d = '0;
              state_d  = (mass_q != '0) ? pme_pkg::ST_DIV_GO : pme_pkg::ST_MUL_V;
            end
            default: ;
          endcase
        end
      end
      pme_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = pme_pkg::ST_DIV_WAIT;
      end
      pme_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (force_q[axis_q][DW-1]) begin
            if (div_quo > Q_NEG_MAX) begin
              accel_d[axis_q] = 32'sh8000_0000;
              clip_d          = 1'b1;
            end else begin
              accel_d[axis_q] = DW'(-div_quo);
            end
          end else if (div_quo > Q_POS_MAX) begin
            accel_d[axis_q] = 32'sh7fff_ffff;
            clip_d          = 1'b1;
          end else begin
            accel_d[axis_q] = div_quo[DW-1:0];
          end
          state_d = pme_pkg::ST_MUL_V;
        end
      end
      pme_pkg::ST_MUL_V: begin
        mul_a   = mag(accel_q[axis_q]);
        mul_b   = dt_q;
        neg_d   = accel_q[axis_q][DW-1];
        state_d = pme_pkg::ST_ADD_V;
      end
      pme_pkg::ST_ADD_V: begin
        vel_d[axis_q] = sum_sat[DW-1:0];
        clip_d        = clip_q | sum_sat[DW];
        state_d       = pme_pkg::ST_MUL_P;
      end
      pme_pkg::ST_MUL_P: begin
        mul_a   = mag(vel_q[axis_q]);
        mul_b   = dt_q;
        neg_d   = vel_q[axis_q][DW-1];
        state_d = pme_pkg::ST_ADD_P;
      end
      pme_pkg::ST_ADD_P: begin
        pos_d[axis_q] = sum_sat[DW-1:0];
        clip_d        = clip_q | sum_sat[DW];
        state_d       = pme_pkg::ST_CHECK;
      end
      pme_pkg::ST_CHECK: begin
        if (outside) begin
          bounce_d[axis_q] = 1'b1;
          state_d          = pme_pkg::ST_MUL_B;
        end else begin
          state_d = pme_pkg::ST_NEXT;
        end
      end
      pme_pkg::ST_MUL_B: begin
        mul_a   = mag(vel_q[axis_q]);
        mul_b   = NINE_TENTHS;
        neg_d   = vel_q[axis_q][DW-1];
        state_d = pme_pkg::ST_BOUNCE;
      end
      pme_pkg::ST_BOUNCE: begin
        // reverse and damp: the damped magnitude stays below 2^31
        vel_d[axis_q] = neg_q ? term[DW-1:0] : -term[DW-1:0];
        state_d       = pme_pkg::ST_NEXT;
      end
      pme_pkg::ST_NEXT: begin
        force_d[axis_q] = '0;
        if (axis_q == LAST_AXIS) begin
          state_d = pme_pkg::ST_OUT;
        end else begin
          axis_d  = axis_q + AW'(1);
          state_d = (mass_q != '0) ? pme_pkg::ST_DIV_GO : pme_pkg::ST_MUL_V;
        end
      end
      pme_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d = 1'b1;
          out_pos_d   = pos_q;
          out_vel_d   = vel_q;
          out_mask_d  = bounce_q;
          out_sat_d   = clip_q;
          state_d     = pme_pkg::ST_IDLE;
        end
      end
      default: state_d = pme_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q  <= MASS_RST;
      limit_q <= LIMIT_RST;
      for (int i = 0; i < pme_pkg::AXES; i++) begin
        start_pos_q[i] <= '0;
        start_vel_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (pme_pkg::cfg_reg_e'(cfg_idx_i))
        pme_pkg::CFG_MASS:        mass_q         <= cfg_data_i;
        pme_pkg::CFG_LIMIT:       limit_q        <= cfg_data_i[pme_pkg::LIMIT_W-1:0];
        pme_pkg::CFG_START_POS_X: start_pos_q[0] <= cfg_data_i;
        pme_pkg::CFG_START_POS_Y: start_pos_q[1] <= cfg_data_i;
        pme_pkg::CFG_START_POS_Z: start_pos_q[2] <= cfg_data_i;
        pme_pkg::CFG_START_VEL_X: start_vel_q[0] <= cfg_data_i;
        pme_pkg::CFG_START_VEL_Y: start_vel_q[1] <= cfg_data_i;
        pme_pkg::CFG_START_VEL_Z: start_vel_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pme_pkg::ST_IDLE;
      axis_q      <= '0;
      clip_q      <= 1'b0;
      bounce_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < pme_pkg::AXES; i++) begin
        force_q[i] <= '0;
        accel_q[i] <= '0;
        vel_q[i]   <= '0;
        pos_q[i]   <= '0;
      end
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      clip_q      <= clip_d;
      bounce_q    <= bounce_d;
      out_valid_q <= out_valid_d;
      force_q     <= force_d;
      accel_q     <= accel_d;
      vel_q       <= vel_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q       <= dt_d;
    neg_q      <= neg_d;
    prod_q     <= prod_d;
    out_pos_q  <= out_pos_d;
    out_vel_q  <= out_vel_d;
    out_mask_q <= out_mask_d;
    out_sat_q  <= out_sat_d;
  end

  assign in_ch.ready        = (state_q == pme_pkg::ST_IDLE);
  assign out_ch.valid       = out_valid_q;
  assign out_ch.pos_x       = out_pos_q[0];
  assign out_ch.pos_y       = out_pos_q[1];
  assign out_ch.pos_z       = out_pos_q[2];
  assign out_ch.vel_x       = out_vel_q[0];
  assign out_ch.vel_y       = out_vel_q[1];
  assign out_ch.vel_z       = out_vel_q[2];
  assign out_ch.bounce_mask = out_mask_q;
  assign out_ch.saturated   = out_sat_q;

endmodule

[rtl/core/pme_checker.sv]
module pme_protocol_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic [pme_pkg::FUNC_W-1:0]   in_func_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i
);

  logic tick_beat;
  logic other_beat;

  assign tick_beat  = in_valid_i && in_ready_i && (in_func_i == pme_pkg::FUNC_TICK);
  assign other_beat = in_valid_i && in_ready_i && (in_func_i != pme_pkg::FUNC_TICK);

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a tick beat takes the sequencer out of idle, so in_ready drops
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_beat |=> !in_ready_i)
    else $error("input taken right after a tick beat");

  // results are only loaded at the end of a tick, never from idle
  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while idle");

  // force, restart and unused codes give no result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    other_beat |=> !$rose(out_valid_i))
    else $error("result after a non-tick beat");

endmodule

bind point_mass_euler_integrator pme_protocol_checker u_pme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .in_func_i   (in_ch.func),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready)
);

[tb/pme_checker.sv]
module pme_checker
  import pme_pkg::*;
#(
  parameter int unsigned FRAC = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pme_in_if                    in_ch,
  pme_out_if                   out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output int                   fails_o,
  output int                   pending_o,
  output int                   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WORD_MAX    = 64'sd2147483647;
  localparam longint WORD_MIN    = -64'sd2147483648;
  localparam longint NINE_TENTHS = ((64'sd9 << FRAC) + 64'sd5) / 64'sd10;

  typedef struct packed {
    logic [AXES-1:0][DATA_W-1:0] pos;
    logic [AXES-1:0][DATA_W-1:0] vel;
    logic [MASK_W-1:0]           bounce;
    logic                        sat;
  } motion_t;

  // Register copy and body state
  logic [DATA_W-1:0]         mass_cfg;
  logic [LIMIT_W-1:0]        limit_cfg;
  logic signed [DATA_W-1:0]  start_pos_cfg [AXES];
  logic signed [DATA_W-1:0]  start_vel_cfg [AXES];
  logic signed [DATA_W-1:0]  net_force     [AXES];
  logic signed [DATA_W-1:0]  accel_now     [AXES];
  logic signed [DATA_W-1:0]  velocity_now  [AXES];
  logic signed [DATA_W-1:0]  position_now  [AXES];

  bit      clip_seen;
  motion_t due_motion [$];
  motion_t got_motion;
  motion_t want_motion;
  int      mismatch_count = 0;
  int      checked_count  = 0;

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    if (v > WORD_MAX) begin
      clip_seen = 1'b1;
      return 32'(WORD_MAX);
    end
    if (v < WORD_MIN) begin
      clip_seen = 1'b1;
      return 32'(WORD_MIN);
    end
    return v[DATA_W-1:0];
  endfunction

  // trunc(a * b / 2^FRAC) on the magnitude, sign restored afterwards
  function automatic longint scale_q(input logic signed [DATA_W-1:0] a, input longint b);
    longint mag;
    mag = (a < 0) ? -longint'(a) : longint'(a);
    mag = (mag * b) >> FRAC;
    return (a < 0) ? -mag : mag;
  endfunction

  function automatic motion_t integrate_tick(input logic [DT_W-1:0] dt);
    motion_t r;
    longint  q;
    longint  dt_l;
    longint  lim;
    r         = '0;
    clip_seen = 1'b0;
    dt_l      = longint'(dt);
    lim       = longint'(limit_cfg);
    for (int ax = 0; ax < AXES; ax++) begin
      if (mass_cfg != '0) begin
        q = (net_force[ax] < 0) ? -longint'(net_force[ax]) : longint'(net_force[ax]);
        q = (q << FRAC) / longint'(mass_cfg);
        accel_now[ax] = clamp32((net_force[ax] < 0) ? -q : q);
      end
      velocity_now[ax] = clamp32(longint'(velocity_now[ax]) + scale_q(accel_now[ax], dt_l));
      position_now[ax] = clamp32(longint'(position_now[ax]) + scale_q(velocity_now[ax], dt_l));
      // strictly outside the box: reverse and damp
      if (longint'(position_now[ax]) > lim || longint'(position_now[ax]) < -lim) begin
        velocity_now[ax] = 32'(-scale_q(velocity_now[ax], NINE_TENTHS));
        r.bounce[ax]     = 1'b1;
      end
      net_force[ax] = '0;
      r.pos[ax]     = position_now[ax];
      r.vel[ax]     = velocity_now[ax];
    end
    r.sat = clip_seen;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    mismatch_count++;
    $display("checker: result %0d %s: got %h, want %h", checked_count, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_cfg  = DATA_W'(1) << FRAC;
      limit_cfg = LIMIT_W'(100) << FRAC;
      for (int ax = 0; ax < AXES; ax++) begin
        start_pos_cfg[ax] = '0;
        start_vel_cfg[ax] = '0;
        net_force[ax]     = '0;
        accel_now[ax]     = '0;
        velocity_now[ax]  = '0;
        position_now[ax]  = '0;
      end
      due_motion.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_MASS:  mass_cfg  = cfg_data_i;
          CFG_LIMIT: limit_cfg = cfg_data_i[LIMIT_W-1:0];
          CFG_START_POS_X, CFG_START_POS_Y, CFG_START_POS_Z: begin
            start_pos_cfg[int'(cfg_idx_i) - int'(CFG_START_POS_X)] = cfg_data_i;
          end
          CFG_START_VEL_X, CFG_START_VEL_Y, CFG_START_VEL_Z: begin
            start_vel_cfg[int'(cfg_idx_i) - int'(CFG_START_VEL_X)] = cfg_data_i;
          end
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        got_motion.pos    = {out_ch.pos_z, out_ch.pos_y, out_ch.pos_x};
        got_motion.vel    = {out_ch.vel_z, out_ch.vel_y, out_ch.vel_x};
        got_motion.bounce = out_ch.bounce_mask;
        got_motion.sat    = out_ch.saturated;
        if (due_motion.size() == 0) begin
          note_mismatch("beat with no tick outstanding", '0, '0);
        end else begin
          want_motion = due_motion.pop_front();
          for (int ax = 0; ax < AXES; ax++) begin
            if (got_motion.pos[ax] !== want_motion.pos[ax]) begin
              note_mismatch($sformatf("pos axis %0d", ax), got_motion.pos[ax],
                            want_motion.pos[ax]);
            end
            if (got_motion.vel[ax] !== want_motion.vel[ax]) begin
              note_mismatch($sformatf("vel axis %0d", ax), got_motion.vel[ax],
                            want_motion.vel[ax]);
            end
          end
          if (got_motion.bounce !== want_motion.bounce) begin
            note_mismatch("bounce_mask", DATA_W'(got_motion.bounce),
                          DATA_W'(want_motion.bounce));
          end
          if (got_motion.sat !== want_motion.sat) begin
            note_mismatch("saturated", DATA_W'(got_motion.sat), DATA_W'(want_motion.sat));
          end
          checked_count++;
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.func)
          FUNC_FORCE: begin
            // force accumulation clips silently
            net_force[0] = clamp32(longint'(net_force[0]) + longint'(in_ch.force_x));
            net_force[1] = clamp32(longint'(net_force[1]) + longint'(in_ch.force_y));
            net_force[2] = clamp32(longint'(net_force[2]) + longint'(in_ch.force_z));
          end
          FUNC_TICK: due_motion.push_back(integrate_tick(in_ch.time_step));
          FUNC_RESTART: begin
            for (int ax = 0; ax < AXES; ax++) begin
              position_now[ax] = start_pos_cfg[ax];
              velocity_now[ax] = start_vel_cfg[ax];
              net_force[ax]    = '0;
              accel_now[ax]    = '0;
            end
          end
          default: ;
        endcase
      end
    end
    pending_o <= due_motion.size();
    fails_o   <= mismatch_count;
    checked_o <= checked_count;
  end

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pme_pkg::*;

  localparam int unsigned FRAC         = 16;
  localparam int          IDLE_PCT     = 11;
  localparam int          HOLD_CYCLES  = 700;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          PHASES       = 6;
  localparam int          PHASE_BEATS  = 100;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_data;
  bit                   idle_en;
  bit                   hold_req;
  bit                   hold_served;
  int                   fails;
  int                   pending;
  int                   checked;
  int                   beats_sent     = 0;
  int                   settings_used  = 1;
  int                   cycle_cnt      = 0;

  pme_in_if  in_ch ();
  pme_out_if out_ch ();

  point_mass_euler_integrator #(
    .FRAC_BITS (FRAC)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  pme_checker #(
    .FRAC (FRAC)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .fails_o    (fails),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served <= 1'b1;
      end else begin
        out_ch.ready <= !(idle_en && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  function automatic logic [DATA_W-1:0] near_zero(input int span);
    return DATA_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [DATA_W-1:0] pick_force();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return near_zero(1 << 20);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] pick_step();
    case ($urandom_range(0, 11))
      0:       return DT_W'($urandom());
      1:       return 24'hFF_FFFF;
      2:       return '0;
      default: return DT_W'($urandom_range(1, 24'h00_8000));
    endcase
  endfunction

  task automatic send_beat(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] fx,
                           input logic [DATA_W-1:0] fy, input logic [DATA_W-1:0] fz,
                           input logic [DT_W-1:0] dt);
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= fn;
    in_ch.force_x   <= fx;
    in_ch.force_y   <= fy;
    in_ch.force_z   <= fz;
    in_ch.time_step <= dt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (fn != FUNC_UNUSED) beats_sent++;
  endtask

  task automatic send_force(input logic [DATA_W-1:0] fx, input logic [DATA_W-1:0] fy,
                            input logic [DATA_W-1:0] fz);
    send_beat(FUNC_FORCE, fx, fy, fz, DT_W'($urandom()));
  endtask

  task automatic send_tick(input logic [DT_W-1:0] dt);
    send_beat(FUNC_TICK, $urandom(), $urandom(), $urandom(), dt);
  endtask

  task automatic send_restart();
    send_beat(FUNC_RESTART, $urandom(), $urandom(), $urandom(), DT_W'($urandom()));
  endtask

  // Drop valid and wait until every tick result is out and the block is quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [DATA_W-1:0] mass_w,
                               input logic [DATA_W-1:0] limit_w,
                               input logic [AXES-1:0][DATA_W-1:0] sp,
                               input logic [AXES-1:0][DATA_W-1:0] sv);
    settle();
    write_reg(CFG_MASS, mass_w);
    write_reg(CFG_LIMIT, limit_w);
    for (int i = 0; i < AXES; i++) write_reg(cfg_reg_e'(int'(CFG_START_POS_X) + i), sp[i]);
    for (int i = 0; i < AXES; i++) write_reg(cfg_reg_e'(int'(CFG_START_VEL_X) + i), sv[i]);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly bursts of forces closed by a tick, with restarts and unused codes mixed in
  task automatic run_phase(input int n);
    int sent;
    int k;
    int r;
    sent = 0;
    send_restart();
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_restart();
        sent++;
      end else if (r < 8) begin
        send_beat(FUNC_UNUSED, $urandom(), $urandom(), $urandom(), DT_W'($urandom()));
      end else begin
        k = $urandom_range(0, 3);
        repeat (k) send_force(pick_force(), pick_force(), pick_force());
        send_tick(pick_step());
        sent += k + 1;
      end
    end
  endtask

  initial begin : stimulus
    logic [AXES-1:0][DATA_W-1:0] sp;
    logic [AXES-1:0][DATA_W-1:0] sv;
    logic [DATA_W-1:0]           mass_w;
    logic [DATA_W-1:0]           limit_w;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_FORCE;
    in_ch.force_x   <= '0;
    in_ch.force_y   <= '0;
    in_ch.force_z   <= '0;
    in_ch.time_step <= '0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_MASS;
    cfg_data        <= '0;
    idle_en         <= 1'b1;
    hold_req        <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero-length tick, clipped force sums, full-scale step
    send_tick('0);
    send_force(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    send_force(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000);
    send_tick(24'hFF_FFFF);
    send_tick(24'h00_0001);
    send_beat(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_restart();
    send_force(32'h0001_0000, 32'hFFFF_0000, 32'h0003_0000);
    send_tick(24'h01_0000);

    // Zero mass keeps the last acceleration; then sit on the box edge (x, z) and just past it (y)
    sp = {32'hFFFF_0000, 32'h0001_0001, 32'h0001_0000};
    sv = '0;
    apply_setting('0, 32'h0001_0000, sp, sv);
    send_tick(24'h01_0000);
    send_force(32'h0005_0000, 32'hFFFB_0000, 32'h0000_0001);
    send_tick(24'h00_4000);
    send_restart();
    send_tick('0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          sp = {32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
          sv = {32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000};
          apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, sp, sv);
        end
        1: begin
          sp = '0;
          for (int i = 0; i < AXES; i++) sv[i] = near_zero(1 << 18);
          apply_setting(32'h0000_0001, '0, sp, sv);
        end
        default: begin
          mass_w  = ($urandom_range(0, 3) == 0) ? $urandom() :
                    DATA_W'($urandom_range(32'h4000, 32'h8_0000));
          limit_w = {1'($urandom_range(0, 1)), 31'($urandom_range(32'h1_0000, 32'h100_0000))};
          for (int i = 0; i < AXES; i++) begin
            sp[i] = near_zero(1 << 22);
            sv[i] = near_zero(1 << 20);
          end
          apply_setting(mass_w, limit_w, sp, sv);
        end
      endcase
      if (p == 2) hold_req <= 1'b1;
      idle_en <= (p != 3);
      run_phase(PHASE_BEATS);
    end

    settle();
    $display("testbench: %0d beats sent under %0d register settings, %0d tick results compared",
             beats_sent, settings_used, checked);
    if (fails == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: %0d mismatches", fails);
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
